FILE: rtl/core/xhpd_pkg.sv
`default_nettype none
package xhpd_pkg;

	localparam int unsigned WinBytes = 16;

	typedef logic [WinBytes-1:0][7:0] win_t;

	localparam logic [2:0] KIND_NONE   = 3'd0;
	localparam logic [2:0] KIND_NEAR   = 3'd1;
	localparam logic [2:0] KIND_SHORT  = 3'd2;
	localparam logic [2:0] KIND_PUSHRT = 3'd3;
	localparam logic [2:0] KIND_VIAMEM = 3'd4;
	localparam logic [2:0] KIND_MOVJMP = 3'd5;
	localparam logic [2:0] KIND_RELOC  = 3'd6;

	localparam logic [7:0] OP_CALL_REL = 8'hE8;
	localparam logic [7:0] OP_JMP_REL  = 8'hE9;
	localparam logic [7:0] OP_JMP_SH   = 8'hEB;
	localparam logic [7:0] OP_PUSH_IMM = 8'h68;
	localparam logic [7:0] OP_RET      = 8'hC3;
	localparam logic [7:0] OP_GRP5     = 8'hFF;
	localparam logic [7:0] MODRM_DISP  = 8'h25;
	localparam logic [4:0] OP_MOV_HI   = 5'b10111;	// 0xB8..0xBF
	localparam logic [3:0] REX_HI      = 4'h4;		// 0x40..0x4F, W at bit 3
	localparam logic [3:0] MODRM_JMP_HI  = 4'hE;	// 0xE0..0xEF
	localparam logic [3:0] MODRM_CALL_HI = 4'hD;	// 0xD0..0xDF

	typedef struct packed {
		logic        match;
		logic [3:0]  len;
		logic [2:0]  kind;
		logic [63:0] target;
		logic        direct;
	} dec_res_t;

endpackage
`default_nettype wire

FILE: rtl/core/xhpd_decode.sv
`default_nettype none
module xhpd_decode
	import xhpd_pkg::*;
(
	input  wire logic        is64,
	input  wire win_t        win,
	input  wire logic [4:0]  avail,
	input  wire logic [63:0] va,
	output dec_res_t         res
);

	logic [31:0] imm32_1;
	logic [31:0] imm32_2;
	logic [63:0] off;
	logic [63:0] imm;
	logic        use_add;

	logic        rex;
	logic        islong;
	logic [7:0]  op2;
	logic [3:0]  j0;
	logic        rex2;
	logic [3:0]  j;
	logic [7:0]  modrm;
	logic        mov_ok;

	assign imm32_1 = {win[4], win[3], win[2], win[1]};
	assign imm32_2 = {win[5], win[4], win[3], win[2]};

	assign rex    = is64 && (win[0][7:4] == REX_HI);
	assign islong = rex && win[0][3];
	assign op2    = rex ? win[1] : win[0];
	assign j0     = rex ? (islong ? 4'd10 : 4'd6) : 4'd5;
	assign rex2   = is64 && (win[j0][7:4] == REX_HI);
	assign j      = j0 + {3'd0, rex2};
	assign modrm  = win[j + 4'd1];

	assign mov_ok = (op2[7:3] == OP_MOV_HI)
		&& (avail >= (islong ? 5'd11 : 5'd7))
		&& (avail >= ({1'b0, j} + 5'd2))
		&& (win[j] == OP_GRP5)
		&& ((modrm[7:4] == MODRM_JMP_HI) || (modrm[7:4] == MODRM_CALL_HI))
		&& !modrm[3]
		&& (modrm[2:0] == op2[2:0]);

	always_comb begin
		res     = '0;
		off     = '0;
		imm     = '0;
		use_add = 1'b0;
		priority if (win[0] == OP_JMP_REL || win[0] == OP_CALL_REL) begin
			res.match  = avail >= 5'd5;
			res.len    = 4'd5;
			res.kind   = KIND_NEAR;
			res.direct = 1'b1;
			use_add    = 1'b1;
			off        = 64'd5 + {{32{imm32_1[31]}}, imm32_1};
		end else if (win[0] == OP_JMP_SH) begin
			res.match  = avail >= 5'd2;
			res.len    = 4'd2;
			res.kind   = KIND_SHORT;
			res.direct = 1'b1;
			use_add    = 1'b1;
			off        = 64'd2 + {{56{win[1][7]}}, win[1]};
		end else if (win[0] == OP_PUSH_IMM) begin
			res.match  = (avail >= 5'd6) && (win[5] == OP_RET);
			res.len    = 4'd6;
			res.kind   = KIND_PUSHRT;
			res.direct = 1'b1;
			imm        = {32'd0, imm32_1};
		end else if (win[0] == OP_GRP5 && win[1] == MODRM_DISP) begin
			res.match  = avail >= 5'd6;
			res.len    = 4'd6;
			res.kind   = KIND_VIAMEM;
			res.direct = 1'b0;
			use_add    = is64;
			off        = 64'd6 + {{32{imm32_2[31]}}, imm32_2};
			imm        = {32'd0, imm32_2};
		end else begin
			res.match  = mov_ok;
			res.len    = j + 4'd2;
			res.kind   = KIND_MOVJMP;
			res.direct = 1'b1;
			if (islong) begin
				imm = {win[9], win[8], win[7], win[6], win[5], win[4], win[3], win[2]};
			end else if (rex) begin
				imm = {32'd0, imm32_2};
			end else begin
				imm = {32'd0, imm32_1};
			end
		end
		res.target = use_add ? (va + off) : imm;
	end

endmodule
`default_nettype wire

FILE: rtl/core/x86_hook_pattern_decoder_unit.sv
// channel   | signals                                                      | dir
// ----------+--------------------------------------------------------------+----
// config    | cfg_we, cfg_wdata                                            | in
// item in   | start, window_low/high, byte_before, has_byte_before,        | in
//           | code_address, bytes_available, is_relocated                  |
// item out  | busy, done, hook_length, hook_kind, target_address, target_direct | out
//
// From start to done an item passes the input register, then the result register.
// One item per cycle; busy is always low.
// arst_n clears the valid flags and sets is64_q to 0.
// The receiver cannot stall; done is a single-cycle strobe.
`default_nettype none
module x86_hook_pattern_decoder_unit
	import xhpd_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic        cfg_wdata,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [63:0] window_low,
	input  wire logic [63:0] window_high,
	input  wire logic [7:0]  byte_before,
	input  wire logic        has_byte_before,
	input  wire logic [63:0] code_address,
	input  wire logic [4:0]  bytes_available,
	input  wire logic        is_relocated,
	output logic             done,
	output logic [3:0]       hook_length,
	output logic [2:0]       hook_kind,
	output logic [63:0]      target_address,
	output logic             target_direct
);

	logic        is64_q;
	logic        valid_s1;
	win_t        win_s1;
	win_t        rwin_s1;
	logic        hbb_s1;
	logic [63:0] va_s1;
	logic [63:0] va_m1_s1;
	logic [4:0]  avail_s1;
	logic [4:0]  ravail_s1;
	logic        reloc_s1;

	logic [4:0]  avail_in;
	win_t        win_in;

	dec_res_t    prim;
	dec_res_t    retry;
	dec_res_t    fin;
	logic        rel_ok;

	logic        done_q;
	logic [3:0]  len_q;
	logic [2:0]  kind_q;
	logic [63:0] tgt_q;
	logic        dir_q;

	assign busy     = 1'b0;
	assign avail_in = (bytes_available > 5'd16) ? 5'd16 : bytes_available;
	assign win_in   = {window_high, window_low};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			is64_q   <= 1'b0;
			valid_s1 <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				is64_q <= cfg_wdata;
			end
			valid_s1 <= start;
			done_q   <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			win_s1    <= win_in;
			rwin_s1   <= {win_in[14:0], byte_before};
			hbb_s1    <= has_byte_before;
			va_s1     <= code_address;
			va_m1_s1  <= code_address - 64'd1;
			avail_s1  <= avail_in;
			ravail_s1 <= (avail_in == 5'd16) ? 5'd16 : avail_in + 5'd1;
			reloc_s1  <= is_relocated;
		end
	end

	xhpd_decode u_prim (
		.is64  (is64_q),
		.win   (win_s1),
		.avail (avail_s1),
		.va    (va_s1),
		.res   (prim)
	);

	xhpd_decode u_retry (
		.is64  (is64_q),
		.win   (rwin_s1),
		.avail (ravail_s1),
		.va    (va_m1_s1),
		.res   (retry)
	);

	assign rel_ok = reloc_s1 && (avail_s1 >= (is64_q ? 5'd8 : 5'd4));

	always_comb begin
		fin = '0;
		priority if (rel_ok) begin
			fin.match  = 1'b1;
			fin.len    = is64_q ? 4'd8 : 4'd4;
			fin.kind   = KIND_RELOC;
			fin.direct = 1'b1;
			fin.target = is64_q ? win_s1[7:0] : {32'd0, win_s1[3:0]};
		end else if (avail_s1 >= 5'd3 && prim.match) begin
			fin = prim;
		end else if (avail_s1 >= 5'd3 && hbb_s1 && retry.match) begin
			fin     = retry;
			fin.len = retry.len - 4'd1;
		end else begin
			fin = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			len_q  <= fin.len;
			kind_q <= fin.kind;
			tgt_q  <= fin.target;
			dir_q  <= fin.direct;
		end
	end

	assign done           = done_q;
	assign hook_length    = len_q;
	assign hook_kind      = kind_q;
	assign target_address = tgt_q;
	assign target_direct  = dir_q;

endmodule
`default_nettype wire
